// ===== rtl/rtv_pkg.sv =====
package rtv_pkg;

    // Quotient bits produced by the divider row, one per cell
    localparam int unsigned QUO_W = 13;
    localparam int unsigned N_CELLS = QUO_W;

    // Width of a running remainder: below twice an 8-bit divisor
    localparam int unsigned REM_W = 9;

    localparam logic [1:0] SECT_RED   = 2'd0;
    localparam logic [1:0] SECT_GREEN = 2'd1;
    localparam logic [1:0] SECT_BLUE  = 2'd2;

    localparam logic [13:0] HUE_FULL = 14'd6144;

    typedef struct packed {
        logic [REM_W-1:0] rem_s;    // saturation: delta * 2^k mod max
        logic [QUO_W-1:0] quo_s;
        logic [7:0]       dsr_s;    // max, also the brightness
        logic [REM_W-1:0] rem_h;    // hue: |diff| * 2^k mod delta
        logic [QUO_W-1:0] quo_h;
        logic [7:0]       dsr_h;    // delta
        logic [1:0]       sector;
        logic             neg;      // diff below zero
        logic             flat;     // delta zero: grey or black
    } t_pix;

    function automatic logic [12:0] hue_base(input logic [1:0] sector);
        logic [12:0] base;
        case (sector)
            SECT_GREEN: base = 13'd2048;
            SECT_BLUE:  base = 13'd4096;
            default:    base = 13'd0;
        endcase
        return base;
    endfunction

endpackage

// ===== rtl/rtv_front.sv =====
module rtv_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [7:0]    i_red,
    input  logic [7:0]    i_green,
    input  logic [7:0]    i_blue,
    output logic          o_valid,
    input  logic          i_ready,
    output rtv_pkg::t_pix o_pix
);

    logic          r_valid;
    rtv_pkg::t_pix r_pix;
    rtv_pkg::t_pix n_pix;

    logic [7:0]        mx;
    logic [7:0]        mn;
    logic [7:0]        delta;
    logic signed [8:0] diff;

    always_comb begin
        mx = i_red;
        mn = i_red;
        if (i_green > mx) mx = i_green;
        if (i_blue > mx) mx = i_blue;
        if (i_green < mn) mn = i_green;
        if (i_blue < mn) mn = i_blue;
        delta = mx - mn;

        n_pix = '0;
        // ties go to blue first, then green
        if (i_blue == mx) begin
            n_pix.sector = rtv_pkg::SECT_BLUE;
            diff = $signed({1'b0, i_red}) - $signed({1'b0, i_green});
        end else if (i_green == mx) begin
            n_pix.sector = rtv_pkg::SECT_GREEN;
            diff = $signed({1'b0, i_blue}) - $signed({1'b0, i_red});
        end else begin
            n_pix.sector = rtv_pkg::SECT_RED;
            diff = $signed({1'b0, i_green}) - $signed({1'b0, i_blue});
        end

        n_pix.neg   = diff[8];
        n_pix.rem_s = {1'b0, delta};
        n_pix.dsr_s = mx;
        n_pix.rem_h = diff[8] ? 9'(~diff + 9'sd1) : {1'b0, diff[7:0]};
        n_pix.dsr_h = delta;
        n_pix.flat  = (delta == 8'd0);
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_pix <= n_pix;
        end
    end

    assign o_valid = r_valid;
    assign o_pix   = r_pix;

endmodule

// ===== rtl/rtv_div_cell.sv =====
module rtv_div_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  rtv_pkg::t_pix i_pix,
    output logic          o_valid,
    input  logic          i_ready,
    output rtv_pkg::t_pix o_pix
);

    logic          r_valid;
    rtv_pkg::t_pix r_pix;
    rtv_pkg::t_pix n_pix;

    logic                      ge_s;
    logic                      ge_h;
    logic [rtv_pkg::REM_W-1:0] sub_s;
    logic [rtv_pkg::REM_W-1:0] sub_h;

    // One restoring step on both dividers: take a quotient bit, then double
    always_comb begin
        n_pix = i_pix;
        ge_s  = i_pix.rem_s >= {1'b0, i_pix.dsr_s};
        ge_h  = i_pix.rem_h >= {1'b0, i_pix.dsr_h};
        sub_s = ge_s ? i_pix.rem_s - {1'b0, i_pix.dsr_s} : i_pix.rem_s;
        sub_h = ge_h ? i_pix.rem_h - {1'b0, i_pix.dsr_h} : i_pix.rem_h;
        n_pix.rem_s = {sub_s[rtv_pkg::REM_W-2:0], 1'b0};
        n_pix.rem_h = {sub_h[rtv_pkg::REM_W-2:0], 1'b0};
        n_pix.quo_s = {i_pix.quo_s[rtv_pkg::QUO_W-2:0], ge_s};
        n_pix.quo_h = {i_pix.quo_h[rtv_pkg::QUO_W-2:0], ge_h};
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_pix <= n_pix;
        end
    end

    assign o_valid = r_valid;
    assign o_pix   = r_pix;

endmodule

// ===== rtl/rtv_back.sv =====
module rtv_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  rtv_pkg::t_pix i_pix,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [12:0]   o_hue,
    output logic [12:0]   o_saturation,
    output logic [7:0]    o_brightness
);

    logic        r_valid;
    logic [12:0] r_hue;
    logic [12:0] r_sat;
    logic [7:0]  r_val;
    logic [12:0] n_hue;
    logic [12:0] n_sat;

    logic [10:0] frac;
    logic        inexact;
    logic [13:0] hsum;

    always_comb begin
        // hue quotient carries two extra bits of fraction; drop them
        frac    = i_pix.quo_h[rtv_pkg::QUO_W-1:2];
        inexact = (i_pix.quo_h[1:0] != 2'd0) || (i_pix.rem_h != '0);
        if (i_pix.neg) begin
            hsum = {1'b0, rtv_pkg::hue_base(i_pix.sector)} - {3'b0, frac}
                 - {13'b0, inexact};
        end else begin
            hsum = {1'b0, rtv_pkg::hue_base(i_pix.sector)} + {3'b0, frac};
        end
        // wrap a negative hue onto the circle
        if (hsum[13]) begin
            hsum = hsum + rtv_pkg::HUE_FULL;
        end
        n_hue = i_pix.flat ? 13'd0 : hsum[12:0];
        n_sat = i_pix.flat ? 13'd0 : i_pix.quo_s;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_hue <= n_hue;
            r_sat <= n_sat;
            r_val <= i_pix.dsr_s;
        end
    end

    assign o_valid      = r_valid;
    assign o_hue        = r_hue;
    assign o_saturation = r_sat;
    assign o_brightness = r_val;

    a_sat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> r_sat <= 13'd4096)
        else $error("saturation above one");

    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> r_hue < 13'd6144)
        else $error("hue outside the circle");

    a_hue_grey: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_sat == 13'd0) |-> r_hue == 13'd0)
        else $error("grey pixel with nonzero hue");

    a_full_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && !i_pix.flat && i_pix.rem_s == '0
         && i_pix.quo_s == 13'd4096) |=> r_valid && r_sat == 13'd4096)
        else $error("full saturation lost at output");

endmodule

// ===== rtl/rgb_to_hsv_converter.sv =====
// RGB to HSV pixel converter.
// Input channel: i_valid / o_ready with i_red, i_green, i_blue (8 bits each).
// Output channel: o_valid / i_ready with o_hue (sixths of a circle, 10 fraction
// bits, 0..6143), o_saturation (4096 is one) and o_brightness (largest channel).
// A pixel transfers when valid and ready are both high on a rising edge.
// From input transfer to o_valid a pixel passes through 15 registered stages:
// the max/min/sector stage, the row of divider cells (one quotient bit per
// cell, saturation and hue dividers side by side), and the hue correction and
// output register. Throughput is one pixel per cycle while the row is not
// full; pixels are independent.
// When the receiver holds i_ready low, results stay put and the row fills up;
// each stage takes a new pixel as long as it or a stage below is free, so
// empty slots are squeezed out and o_ready drops only when all 15 stages hold
// a pixel. Synchronous active-low reset empties every stage; no pixel in
// flight survives it.
module rgb_to_hsv_converter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [12:0] o_hue,
    output logic [12:0] o_saturation,
    output logic [7:0]  o_brightness
);

    logic          stg_valid [rtv_pkg::N_CELLS+1];
    logic          stg_ready [rtv_pkg::N_CELLS+1];
    rtv_pkg::t_pix stg_pix   [rtv_pkg::N_CELLS+1];

    rtv_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_red   (i_red),
        .i_green (i_green),
        .i_blue  (i_blue),
        .o_valid (stg_valid[0]),
        .i_ready (stg_ready[0]),
        .o_pix   (stg_pix[0])
    );

    for (genvar k = 0; k < rtv_pkg::N_CELLS; k++) begin : g_cell
        rtv_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (stg_valid[k]),
            .o_ready (stg_ready[k]),
            .i_pix   (stg_pix[k]),
            .o_valid (stg_valid[k+1]),
            .i_ready (stg_ready[k+1]),
            .o_pix   (stg_pix[k+1])
        );
    end

    rtv_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (stg_valid[rtv_pkg::N_CELLS]),
        .o_ready      (stg_ready[rtv_pkg::N_CELLS]),
        .i_pix        (stg_pix[rtv_pkg::N_CELLS]),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_hue        (o_hue),
        .o_saturation (o_saturation),
        .o_brightness (o_brightness)
    );

endmodule

// ===== verif/testbench.sv =====
module testbench;

    typedef struct packed {
        logic [12:0] hue;
        logic [12:0] sat;
        logic [7:0]  val;
    } t_hsv;

    typedef enum int {
        IDLE_NONE,
        IDLE_MIXED,
        IDLE_HEAVY
    } t_idle_mode;

    localparam int HUE_SIXTH = 1024;
    localparam int SAT_ONE   = 4096;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [7:0]  i_red   = 8'd0;
    logic [7:0]  i_green = 8'd0;
    logic [7:0]  i_blue  = 8'd0;
    logic        i_ready = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [12:0] o_hue;
    logic [12:0] o_saturation;
    logic [7:0]  o_brightness;

    t_hsv       expected_hsv[$];
    t_idle_mode tx_mode = IDLE_NONE;
    t_idle_mode rx_mode = IDLE_NONE;
    int         rx_hold = 0;
    int         errors = 0;
    int         pixels_sent = 0;
    int         results_checked = 0;
    int         grey_pixels = 0;
    int         black_pixels = 0;

    rgb_to_hsv_converter dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_red        (i_red),
        .i_green      (i_green),
        .i_blue       (i_blue),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_hue        (o_hue),
        .o_saturation (o_saturation),
        .o_brightness (o_brightness)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic t_hsv rgb_to_hsv(input logic [7:0] r, input logic [7:0] g,
                                        input logic [7:0] b);
        int   rv, gv, bv, mx, mn, delta, diff, base, num, quo, hue_v;
        t_hsv res;
        rv = int'(r);
        gv = int'(g);
        bv = int'(b);
        mx = rv;
        mn = rv;
        if (gv > mx) mx = gv;
        if (bv > mx) mx = bv;
        if (gv < mn) mn = gv;
        if (bv < mn) mn = bv;
        delta = mx - mn;
        res.val = mx[7:0];
        res.hue = '0;
        res.sat = '0;
        if (mx != 0 && delta != 0) begin
            res.sat = 13'((delta * SAT_ONE) / mx);
            // blue wins a tie for the max, then green
            if (bv == mx) begin
                base = 4 * HUE_SIXTH;
                diff = rv - gv;
            end else if (gv == mx) begin
                base = 2 * HUE_SIXTH;
                diff = bv - rv;
            end else begin
                base = 0;
                diff = gv - bv;
            end
            num = diff * HUE_SIXTH;
            // round toward minus infinity
            if (num >= 0)
                quo = num / delta;
            else
                quo = -((-num + delta - 1) / delta);
            hue_v = base + quo;
            if (hue_v < 0)
                hue_v += int'(rtv_pkg::HUE_FULL);
            if (hue_v > int'(rtv_pkg::HUE_FULL))
                hue_v -= int'(rtv_pkg::HUE_FULL);
            res.hue = hue_v[12:0];
        end
        return res;
    endfunction

    function automatic int idle_len(input t_idle_mode mode);
        int pick;
        pick = $urandom_range(0, 99);
        case (mode)
            IDLE_MIXED: begin
                if (pick < 50) return 0;
                if (pick < 85) return $urandom_range(1, 3);
                return $urandom_range(8, 40);
            end
            IDLE_HEAVY: begin
                if (pick < 30) return 0;
                if (pick < 70) return $urandom_range(1, 5);
                return $urandom_range(20, 60);
            end
            default: return 0;
        endcase
    endfunction

    // Output side: random stalls on i_ready
    always @(posedge i_clk) begin
        if (rx_hold != 0) begin
            i_ready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end else begin
            i_ready <= 1'b1;
            if (rx_mode != IDLE_NONE && $urandom_range(0, 2) == 0)
                rx_hold <= idle_len(rx_mode);
        end
    end

    task automatic report_field(input string field, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, act_v);
            errors++;
        end
    endtask

    // Record accepted pixels, check each result transfer against the oldest prediction
    always @(posedge i_clk) begin
        t_hsv exp_v;
        if (i_rst_n) begin
            if (i_valid && o_ready)
                expected_hsv.push_back(rgb_to_hsv(i_red, i_green, i_blue));
            if (o_valid && i_ready) begin
                if (expected_hsv.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual hue %0d sat %0d val %0d",
                             $time, o_hue, o_saturation, o_brightness);
                    errors++;
                end else begin
                    exp_v = expected_hsv.pop_front();
                    report_field("hue", exp_v.hue, o_hue);
                    report_field("saturation", exp_v.sat, o_saturation);
                    report_field("brightness", exp_v.val, o_brightness);
                    results_checked++;
                end
            end
        end
    end

    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        int gap;
        i_valid <= 1'b1;
        i_red   <= r;
        i_green <= g;
        i_blue  <= b;
        do @(posedge i_clk); while (!o_ready);
        pixels_sent++;
        if (r == g && g == b) begin
            if (r == 8'd0) black_pixels++;
            else grey_pixels++;
        end
        gap = idle_len(tx_mode);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic logic [7:0] pick_channel();
        case ($urandom_range(0, 5))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'($urandom_range(1, 2));
            3: return 8'($urandom_range(253, 254));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Uniform pixels, plus ties, greys and channels near the extremes
    task automatic send_random_pixel();
        logic [7:0] r, g, b, shared;
        r = 8'($urandom_range(0, 255));
        g = 8'($urandom_range(0, 255));
        b = 8'($urandom_range(0, 255));
        shared = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 9))
            0: begin r = shared; g = shared; b = shared; end
            1: begin r = shared; g = shared; end
            2: begin g = shared; b = shared; end
            3: begin r = shared; b = shared; end
            4, 5: begin r = pick_channel(); g = pick_channel(); b = pick_channel(); end
            default: ;
        endcase
        send_pixel(r, g, b);
    endtask

    task automatic test_corner_pixels();
        tx_mode = IDLE_MIXED;
        rx_mode = IDLE_MIXED;
        send_pixel(8'd0, 8'd0, 8'd0);         // black
        send_pixel(8'd255, 8'd255, 8'd255);   // white
        send_pixel(8'd128, 8'd128, 8'd128);   // grey
        send_pixel(8'd1, 8'd1, 8'd1);
        send_pixel(8'd255, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd1);       // red max, hue wraps below zero
        send_pixel(8'd255, 8'd1, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd0);     // red and green tie
        send_pixel(8'd0, 8'd255, 8'd255);     // green and blue tie
        send_pixel(8'd255, 8'd0, 8'd255);     // red and blue tie
        send_pixel(8'd1, 8'd0, 8'd0);
        send_pixel(8'd0, 8'd1, 8'd0);
        send_pixel(8'd0, 8'd0, 8'd1);
        send_pixel(8'd255, 8'd254, 8'd0);
        send_pixel(8'd254, 8'd255, 8'd0);
        send_pixel(8'd255, 8'd0, 8'd254);
        send_pixel(8'd1, 8'd0, 8'd255);
        send_pixel(8'd0, 8'd254, 8'd255);
        send_pixel(8'd200, 8'd100, 8'd150);
        send_pixel(8'd10, 8'd20, 8'd30);
        send_pixel(8'd255, 8'd128, 8'd128);
        send_pixel(8'd128, 8'd255, 8'd255);
    endtask

    // Back-to-back pixels, receiver always ready
    task automatic test_full_rate();
        tx_mode = IDLE_NONE;
        rx_mode = IDLE_NONE;
        repeat (300) send_random_pixel();
    endtask

    task automatic test_random_idle();
        tx_mode = IDLE_MIXED;
        rx_mode = IDLE_MIXED;
        repeat (500) send_random_pixel();
    endtask

    // Long output stalls with a busy sender fill the pipeline and drop o_ready
    task automatic test_output_stall();
        tx_mode = IDLE_NONE;
        rx_mode = IDLE_HEAVY;
        repeat (250) send_random_pixel();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_corner_pixels();
        test_full_rate();
        test_random_idle();
        test_output_stall();
        i_valid <= 1'b0;
        while (expected_hsv.size() != 0) @(posedge i_clk);
        rx_mode = IDLE_NONE;
        repeat (40) @(posedge i_clk);
        $display("Converted %0d pixels (%0d grey, %0d black), checked %0d results,",
                 pixels_sent, grey_pixels, black_pixels, results_checked);
        $display("under full rate, random idling and long output stalls.");
        if (errors == 0)
            $display("[rgb_to_hsv_converter] OK");
        else
            $display("[rgb_to_hsv_converter] ERROR");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Timed out with %0d results outstanding", expected_hsv.size());
        $display("[rgb_to_hsv_converter] ERROR");
        $finish;
    end

endmodule
